FILE: rtl/fve_pkg.sv
// shared types, constants and the microcode table of the volume fade envelope
package fve_pkg;

    localparam int          PC_W       = 4;
    localparam int          DIV_W      = 16;
    localparam int          CNT_W      = 4;
    localparam logic [15:0] FULL_LEVEL = 16'h8000;
    localparam int          OUT_W      = 56;

    typedef enum logic [1:0] {
        KIND_RESET = 2'd0,
        KIND_IN    = 2'd1,
        KIND_STOP  = 2'd2,
        KIND_PAUSE = 2'd3
    } fade_kind_t;

    typedef enum logic [1:0] {
        REG_SEQ_VOL    = 2'd0,
        REG_PLAYER_VOL = 2'd1,
        REG_TRACK_GAIN = 2'd2,
        REG_TRACK_MASK = 2'd3
    } reg_index_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_UPDATE,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_END,
        OP_MUL_A,
        OP_MUL_B,
        OP_MUL_C,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_IN,
        C_NEXT,
        C_DIV,
        C_LOOP,
        C_OUT,
        C_JUMP
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ucode_t;

    typedef struct packed {
        op_t  op;
        logic in_ready;
    } ctrl_t;

    typedef struct packed {
        logic in_fire;
        logic need_div;
        logic loop_more;
        logic out_free;
    } status_t;

    localparam logic [PC_W-1:0] PC_WAIT   = 4'd0;
    localparam logic [PC_W-1:0] PC_UPDATE = 4'd1;
    localparam logic [PC_W-1:0] PC_DSTEP  = 4'd3;
    localparam logic [PC_W-1:0] PC_MUL_A  = 4'd5;

    function automatic ucode_t fve_ucode(input logic [PC_W-1:0] pc);
        ucode_t w;
        unique case (pc)
            4'd0:    w = '{op: OP_IDLE,     cond: C_IN,   target: PC_UPDATE};
            4'd1:    w = '{op: OP_UPDATE,   cond: C_DIV,  target: PC_MUL_A};
            4'd2:    w = '{op: OP_DIV_INIT, cond: C_NEXT, target: PC_WAIT};
            4'd3:    w = '{op: OP_DIV_STEP, cond: C_LOOP, target: PC_DSTEP};
            4'd4:    w = '{op: OP_DIV_END,  cond: C_NEXT, target: PC_WAIT};
            4'd5:    w = '{op: OP_MUL_A,    cond: C_NEXT, target: PC_WAIT};
            4'd6:    w = '{op: OP_MUL_B,    cond: C_NEXT, target: PC_WAIT};
            4'd7:    w = '{op: OP_MUL_C,    cond: C_NEXT, target: PC_WAIT};
            4'd8:    w = '{op: OP_EMIT,     cond: C_OUT,  target: PC_WAIT};
            default: w = '{op: OP_IDLE,     cond: C_JUMP, target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/fve_sequencer.sv
// step counter and microcode lookup with conditional jumps
module fve_sequencer (
    input  logic             aclk,
    input  logic             aresetn,
    input  fve_pkg::status_t status,
    output fve_pkg::ctrl_t   ctrl
);
    import fve_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    ucode_t          uc;

    assign uc            = fve_ucode(pc_reg);
    assign ctrl.op       = uc.op;
    assign ctrl.in_ready = (uc.cond == C_IN);

    always_comb begin
        unique case (uc.cond)
            C_IN:    pc_next = status.in_fire ? uc.target : pc_reg;
            C_NEXT:  pc_next = pc_reg + 1'b1;
            C_DIV:   pc_next = status.need_div ? pc_reg + 1'b1 : uc.target;
            C_LOOP:  pc_next = status.loop_more ? uc.target : pc_reg + 1'b1;
            C_OUT:   pc_next = status.out_free ? uc.target : pc_reg;
            C_JUMP:  pc_next = uc.target;
            default: pc_next = PC_WAIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

FILE: rtl/fve_datapath.sv
// fade state, config registers, serial divider, multipliers and output register
module fve_datapath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  fve_pkg::ctrl_t            ctrl,
    output fve_pkg::status_t          status,
    input  logic                      s_tvalid,
    input  logic [15:0]               s_tdata,
    input  logic [2:0]                s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [fve_pkg::OUT_W-1:0] m_tdata,
    input  logic                      cfg_valid,
    input  logic [1:0]                cfg_index,
    input  logic [15:0]               cfg_data
);
    import fve_pkg::*;

    logic [7:0]  seq_vol_reg;
    logic [15:0] player_vol_reg;
    logic [15:0] track_gain_reg;
    logic [15:0] track_mask_reg;

    fade_kind_t  mode_reg;
    logic [15:0] env_reg;
    logic [15:0] step_reg;

    logic        act_reg;
    fade_kind_t  kind_reg;
    logic [15:0] dur_reg;
    logic        stop_reg;
    logic        pause_reg;
    logic        unpause_reg;

    logic [DIV_W:0]   rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [23:0]      p1_reg;
    logic [39:0]      p2_reg;
    logic [39:0]      t_reg;

    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    fade_kind_t  mode_next;
    logic [15:0] env_next;
    logic [15:0] step_next;
    logic        stop_next;
    logic        pause_next;
    logic        unpause_next;
    logic [15:0] sum;

    logic [15:0]    div_d;
    logic [DIV_W:0] r_sh;
    logic           ge;
    logic [7:0]     master;
    logic [7:0]     track;
    logic           in_fire;
    logic           emit;

    assign in_fire          = s_tvalid && ctrl.in_ready;
    assign status.in_fire   = in_fire;
    assign status.need_div  = act_reg && ((kind_reg == KIND_IN) ||
                              ((kind_reg == KIND_STOP || kind_reg == KIND_PAUSE) &&
                               (dur_reg != 16'd0)));
    assign status.loop_more = (cnt_reg != '0);
    assign status.out_free  = !out_valid_reg || m_tready;
    assign emit             = (ctrl.op == OP_EMIT) && status.out_free;

    // state update for one request, before the step from the divider lands
    always_comb begin
        mode_next    = mode_reg;
        env_next     = env_reg;
        step_next    = step_reg;
        stop_next    = 1'b0;
        pause_next   = 1'b0;
        unpause_next = 1'b0;
        sum          = env_reg + step_reg;
        if (act_reg) begin
            unique case (kind_reg)
                KIND_RESET: begin
                    env_next  = FULL_LEVEL;
                    step_next = 16'd0;
                    mode_next = KIND_RESET;
                end
                KIND_IN: begin
                    if (mode_reg == KIND_RESET) begin
                        env_next = 16'd0;
                    end
                    unpause_next = 1'b1;
                    mode_next    = KIND_IN;
                end
                KIND_STOP, KIND_PAUSE: begin
                    if (mode_reg == KIND_RESET) begin
                        env_next = FULL_LEVEL;
                    end
                    mode_next = kind_reg;
                    if (dur_reg == 16'd0) begin
                        // zero-length fade out goes straight to silence
                        env_next  = 16'd0;
                        step_next = 16'd1;
                        if (kind_reg == KIND_STOP) begin
                            mode_next = KIND_RESET;
                            stop_next = 1'b1;
                        end else begin
                            pause_next = 1'b1;
                        end
                    end
                end
            endcase
        end else begin
            unique case (mode_reg)
                KIND_RESET: begin
                end
                KIND_IN: begin
                    if (sum[15]) begin
                        mode_next = KIND_RESET;
                        env_next  = FULL_LEVEL;
                        step_next = 16'd0;
                    end else begin
                        env_next = sum;
                    end
                end
                KIND_STOP: begin
                    if (env_reg < step_reg) begin
                        mode_next = KIND_RESET;
                        env_next  = 16'd0;
                        stop_next = 1'b1;
                    end else begin
                        env_next = env_reg - step_reg;
                    end
                end
                KIND_PAUSE: begin
                    if (env_reg < step_reg) begin
                        env_next   = 16'd0;
                        pause_next = 1'b1;
                    end else begin
                        env_next = env_reg - step_reg;
                    end
                end
            endcase
        end
    end

    // restoring divide of full level by the duration, one bit a step
    assign div_d = (dur_reg == 16'd0) ? 16'd1 : dur_reg;
    assign r_sh  = {rem_reg[DIV_W-1:0], quo_reg[DIV_W-1]};
    assign ge    = (r_sh >= {1'b0, div_d});

    assign master = (|p2_reg[39:31]) ? 8'hFF : p2_reg[30:23];
    assign track  = (|t_reg[39:23])  ? 8'hFF : t_reg[22:15];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_vol_reg    <= 8'd100;
            player_vol_reg <= 16'd256;
            track_gain_reg <= 16'd256;
            track_mask_reg <= 16'd0;
            mode_reg       <= KIND_RESET;
            env_reg        <= FULL_LEVEL;
            step_reg       <= 16'd0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (reg_index_t'(cfg_index))
                    REG_SEQ_VOL:    seq_vol_reg    <= cfg_data[7:0];
                    REG_PLAYER_VOL: player_vol_reg <= cfg_data;
                    REG_TRACK_GAIN: track_gain_reg <= cfg_data;
                    REG_TRACK_MASK: track_mask_reg <= cfg_data;
                endcase
            end
            if (ctrl.op == OP_UPDATE) begin
                mode_reg <= mode_next;
                env_reg  <= env_next;
                step_reg <= step_next;
            end
            if (ctrl.op == OP_DIV_END) begin
                step_reg <= quo_reg;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            act_reg  <= s_tuser[0];
            kind_reg <= fade_kind_t'(s_tuser[2:1]);
            dur_reg  <= s_tdata;
        end
        if (ctrl.op == OP_UPDATE) begin
            stop_reg    <= stop_next;
            pause_reg   <= pause_next;
            unpause_reg <= unpause_next;
        end
        unique case (ctrl.op)
            OP_DIV_INIT: begin
                rem_reg <= '0;
                quo_reg <= FULL_LEVEL;
                cnt_reg <= CNT_W'(DIV_W - 1);
            end
            OP_DIV_STEP: begin
                rem_reg <= ge ? (r_sh - {1'b0, div_d}) : r_sh;
                quo_reg <= {quo_reg[DIV_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
            end
            OP_MUL_A: p1_reg <= 24'(seq_vol_reg) * 24'(player_vol_reg);
            OP_MUL_B: p2_reg <= 40'(p1_reg) * 40'(env_reg);
            OP_MUL_C: t_reg  <= 40'(p2_reg[39:16]) * 40'(track_gain_reg);
            default: begin
            end
        endcase
        if (emit) begin
            out_data_reg <= {3'b000, env_reg, mode_reg, unpause_reg, pause_reg, stop_reg,
                             track_mask_reg, track, master};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: rtl/volume_fade_envelope_core.sv
// top level of the volume fade envelope engine
//
//  channel | direction | handshake              | payload
//  s_      | in        | s_tvalid / s_tready    | tdata fade_duration, tuser action, fade_kind
//  m_      | out       | m_tvalid / m_tready    | tdata levels, select, pulses, mode, envelope
//  cfg_    | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// m_tvalid rises when the result of an accepted request is emitted, both for a tick and for
// a fade start that divides by its duration; s_tready returns with it.
// a fade start that divides by its duration runs 16 passes of a one-bit restoring divider;
// every request then goes through three registered multiplies, each feeding the next.
// one request is worked at a time; s_tready is high only in the wait step.
// a held result does not block the next request, only the emit step waits for m_tready.
// synchronous active-low reset restores the config defaults, full envelope, no fade.
// cfg_ready is always high.
module volume_fade_envelope_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [15:0]               s_tdata,   // fade_duration[15:0]
    input  logic [2:0]                s_tuser,   // action[0], fade_kind[2:1]
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // master_level[7:0], track_level[15:8], track_select[31:16], stop_pulse[32],
    // pause_pulse[33], unpause_pulse[34], fade_mode[36:35], envelope_level[52:37]
    output logic [fve_pkg::OUT_W-1:0] m_tdata,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [15:0]               cfg_data
);
    import fve_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    assign s_tready  = ctrl.in_ready;
    assign cfg_ready = 1'b1;

    fve_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    fve_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .status    (status),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

FILE: rtl/fve_checker.sv
// port-level checks of the volume fade envelope core and their bind
module fve_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [fve_pkg::OUT_W-1:0] m_tdata
);
    import fve_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // only one request in flight
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while one is in progress");

    // envelope never goes above full level
    a_env_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[52:37] <= FULL_LEVEL)
        else $error("envelope above full level");

    // a stop always leaves the player with no fade
    a_stop_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[32] |-> m_tdata[36:35] == KIND_RESET)
        else $error("stop pulse with a fade still running");

    // a pause comes only from the fade out and pause mode
    a_pause_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[33] |-> m_tdata[36:35] == KIND_PAUSE && !m_tdata[32])
        else $error("pause pulse outside the pause fade");

endmodule

bind volume_fade_envelope_core fve_checker u_fve_checker (.*);
